/* rtl/assert_macros.svh */
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/crlf_pkg.sv */
`timescale 1ns / 1ps
// Package: constants, codes and types of the CRLF line receiver
package crlf_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    localparam logic [1:0] OP_RECV  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [BUF_AW-1:0] count;
        logic              cr;
        logic              done;
    } t_status;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

endpackage

/* rtl/crlf_ifs.sv */
`timescale 1ns / 1ps
// Interfaces: input beat channel and result beat channel
interface crlf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, output opcode, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input opcode, input rx_byte, input read_index,
                    output ready);
endinterface

interface crlf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic [7:0] line_length;
    logic       cr_pending;
    logic       line_done;

    modport source (output valid, output read_byte, output line_length,
                    output cr_pending, output line_done, input ready);
    modport sink   (input valid, input read_byte, input line_length,
                    input cr_pending, input line_done, output ready);
endinterface

/* rtl/crlf_line_receiver_top.sv */
`timescale 1ns / 1ps
// Top level: CRLF line receiver with line store memory and result pipeline
// A result passes through stage 1 into the output register; a stall can hold it in stage 1.
// Throughput: one beat per cycle while the output is not stalled; the store takes one write or one read per beat.
// Stage 1 parts input and output, so an input beat is taken while a result waits, if stage 1 is empty.
// Reset clears length, both flags and the pipeline valids.
// The line store is not cleared; its entries hold garbage until written.
`include "assert_macros.svh"
module crlf_line_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crlf_in_if.sink     i_in,
    crlf_out_if.source  o_out
);
    import crlf_pkg::*;

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rd_data;

    t_status    ctl_status;
    t_wr_req    ctl_wr;

    logic       acc;
    logic       s1_adv;
    logic       rd_en;
    logic       rd_in_range;

    logic       r_s1_valid;
    logic       r_s1_rd_ok;
    t_status    r_s1_status;

    logic       r_out_valid;
    logic [7:0] r_out_rd;
    t_status    r_out_status;

    assign s1_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign acc        = i_in.valid && i_in.ready;

    assign rd_in_range = (32'(i_in.read_index) < 32'(BUF_DEPTH));
    assign rd_en       = acc && (i_in.opcode == OP_READ);

    crlf_line_ctl u_ctl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (acc),
        .i_opcode  (i_in.opcode),
        .i_rx_byte (i_in.rx_byte),
        .o_status  (ctl_status),
        .o_wr      (ctl_wr)
    );

    // Store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (ctl_wr.en) begin
            r_mem[ctl_wr.addr] <= ctl_wr.data;
        end
        // hold read data while the beat waits in stage 1
        if (rd_en) begin
            r_rd_data <= r_mem[BUF_AW'(i_in.read_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= acc;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_rd_ok  <= rd_en && rd_in_range;
            r_s1_status <= ctl_status;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_rd     <= r_s1_rd_ok ? r_rd_data : 8'd0;
            r_out_status <= r_s1_status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_byte   = r_out_rd;
    assign o_out.line_length = 8'(r_out_status.count);
    assign o_out.cr_pending  = r_out_status.cr;
    assign o_out.line_done   = r_out_status.done;

    `ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_adv, r_s1_valid, "stage 1 beat lost while stalled")
    `ASSERT_SAME(a_done_has_cr, i_clk, i_rst_n, o_out.valid && o_out.line_done, o_out.cr_pending, "line done without CR flag")
    `ASSERT_NEXT(a_rd_only_read, i_clk, i_rst_n, acc && (i_in.opcode != OP_READ), !r_s1_rd_ok, "read data enabled for a non-read beat")
    `ASSERT_SAME(a_no_wr_on_read, i_clk, i_rst_n, rd_en, !ctl_wr.en, "store write on a read beat")

endmodule

/* rtl/crlf_line_ctl.sv */
`timescale 1ns / 1ps
// Line control: running length, CR and done flags, store write requests
module crlf_line_ctl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_rx_byte,
    output crlf_pkg::t_status o_status,
    output crlf_pkg::t_wr_req o_wr
);
    import crlf_pkg::*;

    t_status r_stat;
    t_status n_stat;
    t_wr_req n_wr;

    always_comb begin
        n_stat  = r_stat;
        n_wr    = '0;
        n_wr.addr = r_stat.count;
        n_wr.data = i_rx_byte;
        if (i_accept) begin
            case (i_opcode)
                OP_RECV: begin
                    if (r_stat.done) begin
                        // drop bytes until cleared
                    end else if (r_stat.cr) begin
                        if (i_rx_byte == CH_LF) begin
                            n_stat.done = 1'b1;
                        end else begin
                            n_stat = '0;
                        end
                    end else if (i_rx_byte == CH_CR) begin
                        n_stat.cr = 1'b1;
                    end else begin
                        n_wr.en = 1'b1;
                        // wrap and restart when the store is full
                        if (r_stat.count == BUF_AW'(BUF_DEPTH - 1)) begin
                            n_stat = '0;
                        end else begin
                            n_stat.count = r_stat.count + 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    n_stat = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat <= '0;
        end else begin
            r_stat <= n_stat;
        end
    end

    assign o_status = n_stat;
    assign o_wr     = n_wr;

endmodule
